### rtl/psp_pkg.sv
// ----------------------------------------------------------------------------
// psp_pkg: shared types and constants for the point/sphere push-out block
// Coordinate formats, item structs and register indexes.
// ----------------------------------------------------------------------------
package psp_pkg;

   // signed Q7.16 coordinates, unsigned radius one bit narrower
   localparam int COORD_WIDTH = 24;
   localparam int FRAC_BITS   = 16;
   localparam int RAD_WIDTH   = COORD_WIDTH - 1;
   localparam int CSR_IDX_WIDTH = 2;

   localparam logic [RAD_WIDTH-1:0] RADIUS_RESET = RAD_WIDTH'(1) << FRAC_BITS;

   // register indexes
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_CENTER_X = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_CENTER_Y = 2'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_CENTER_Z = 2'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_RADIUS   = 2'd3;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] point_x;
      logic signed [COORD_WIDTH-1:0] point_y;
      logic signed [COORD_WIDTH-1:0] point_z;
   } req_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] out_x;
      logic signed [COORD_WIDTH-1:0] out_y;
      logic signed [COORD_WIDTH-1:0] out_z;
      logic                          collided;
   } rsp_type;

endpackage

### rtl/psp_sqrt.sv
// ----------------------------------------------------------------------------
// psp_sqrt: pipelined integer square root
// One result bit per stage, floor(sqrt(rad)); a side payload rides along.
// ----------------------------------------------------------------------------
module psp_sqrt #(
   parameter int RW = 23,
   parameter int PW = 8
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   input  logic [2*RW-1:0] in_rad,
   input  logic [PW-1:0]   in_pay,
   output logic            out_valid,
   output logic [RW-1:0]   out_root,
   output logic [PW-1:0]   out_pay
);

   logic            valid_ff [RW];
   logic [RW:0]     rem_ff   [RW];
   logic [RW-1:0]   root_ff  [RW];
   logic [2*RW-1:0] rad_ff   [RW];
   logic [PW-1:0]   pay_ff   [RW];

   genvar k;
   generate
      for (k = 0; k < RW; k++) begin : g_step
         logic            st_valid;
         logic [RW:0]     st_rem;
         logic [RW-1:0]   st_root;
         logic [2*RW-1:0] st_rad;
         logic [PW-1:0]   st_pay;
         logic [RW+1:0]   trial_rem;
         logic [RW+1:0]   trial_sub;
         logic            ge;
         logic [RW:0]     rem_in;
         logic [RW-1:0]   root_in;

         // pick the stage inputs
         if (k == 0) begin : g_first
            assign st_valid = in_valid;
            assign st_rem   = '0;
            assign st_root  = '0;
            assign st_rad   = in_rad;
            assign st_pay   = in_pay;
         end else begin : g_next
            assign st_valid = valid_ff[k-1];
            assign st_rem   = rem_ff[k-1];
            assign st_root  = root_ff[k-1];
            assign st_rad   = rad_ff[k-1];
            assign st_pay   = pay_ff[k-1];
         end

         // bring down two radicand bits and try the next root bit
         always_comb begin
            trial_rem = {st_rem[RW-1:0], st_rad[2*RW-1:2*RW-2]};
            trial_sub = {st_root, 2'b01};
            ge        = (trial_rem >= trial_sub);
            rem_in    = ge ? RW'(0) + (RW+1)'(trial_rem - trial_sub)
                           : (RW+1)'(trial_rem);
            root_in   = {st_root[RW-2:0], ge};
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[k] <= 1'b0;
            end else begin
               valid_ff[k] <= st_valid;
            end
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            rad_ff[k]  <= st_rad << 2;
            pay_ff[k]  <= st_pay;
         end
      end
   endgenerate

   assign out_valid = valid_ff[RW-1];
   assign out_root  = root_ff[RW-1];
   assign out_pay   = pay_ff[RW-1];

endmodule

### rtl/psp_div.sv
// ----------------------------------------------------------------------------
// psp_div: pipelined three-lane restoring divider
// Divides three numerators by one shared divisor, one quotient bit per stage.
// The quotient must fit RW bits (upper numerator part below the divisor).
// ----------------------------------------------------------------------------
module psp_div #(
   parameter int RW = 23,
   parameter int PW = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [2:0][2*RW:0]   in_num,
   input  logic [RW-1:0]        in_den,
   input  logic [PW-1:0]        in_pay,
   output logic                 out_valid,
   output logic [2:0][RW-1:0]   out_quo,
   output logic [PW-1:0]        out_pay
);

   logic                 valid_ff [RW];
   logic [2:0][RW-1:0]   rem_ff   [RW];
   logic [2:0][RW-1:0]   lo_ff    [RW];
   logic [2:0][RW-1:0]   quo_ff   [RW];
   logic [RW-1:0]        den_ff   [RW];
   logic [PW-1:0]        pay_ff   [RW];

   genvar k, a;
   generate
      for (k = 0; k < RW; k++) begin : g_step
         logic                 st_valid;
         logic [2:0][RW-1:0]   st_rem;
         logic [2:0][RW-1:0]   st_lo;
         logic [2:0][RW-1:0]   st_quo;
         logic [RW-1:0]        st_den;
         logic [PW-1:0]        st_pay;
         logic [2:0][RW-1:0]   rem_in;
         logic [2:0][RW-1:0]   quo_in;

         // pick the stage inputs
         if (k == 0) begin : g_first
            for (a = 0; a < 3; a++) begin : g_lane0
               assign st_rem[a] = in_num[a][2*RW-1:RW];
               assign st_lo[a]  = in_num[a][RW-1:0];
               assign st_quo[a] = '0;
            end
            assign st_valid = in_valid;
            assign st_den   = in_den;
            assign st_pay   = in_pay;
         end else begin : g_next
            assign st_valid = valid_ff[k-1];
            assign st_rem   = rem_ff[k-1];
            assign st_lo    = lo_ff[k-1];
            assign st_quo   = quo_ff[k-1];
            assign st_den   = den_ff[k-1];
            assign st_pay   = pay_ff[k-1];
         end

         // shift in the next numerator bit and subtract where it fits
         for (a = 0; a < 3; a++) begin : g_lane
            logic [RW:0] trial;
            logic        ge;
            always_comb begin
               trial     = {st_rem[a], st_lo[a][RW-1]};
               ge        = (trial >= {1'b0, st_den});
               rem_in[a] = ge ? RW'(trial - {1'b0, st_den}) : RW'(trial);
               quo_in[a] = {st_quo[a][RW-2:0], ge};
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[k] <= 1'b0;
            end else begin
               valid_ff[k] <= st_valid;
            end
            rem_ff[k] <= rem_in;
            for (int i = 0; i < 3; i++) begin
               lo_ff[k][i] <= st_lo[i] << 1;
            end
            quo_ff[k] <= quo_in;
            den_ff[k] <= st_den;
            pay_ff[k] <= st_pay;
         end
      end
   endgenerate

   assign out_valid = valid_ff[RW-1];
   assign out_quo   = quo_ff[RW-1];
   assign out_pay   = pay_ff[RW-1];

endmodule

### rtl/point_sphere_push_out.sv
// ----------------------------------------------------------------------------
// point_sphere_push_out: push cloth points out of a sphere
// Tests each point against a configured sphere and projects it onto the
// surface when it lies strictly inside.
// ----------------------------------------------------------------------------
// One point enters per clock cycle, every cycle; busy stays low. Each point
// gives one result, shown with rsp_strobe for a single cycle once it has
// passed 4 setup stages, one stage per root bit of the square root, one
// scaling multiply, one stage per quotient bit of the divider and one
// output stage. The receiver must take each result when it appears.
// Write the sphere registers only while no point is in flight.
// A point exactly at the center comes back unchanged, with collided set when the radius is nonzero.
// ----------------------------------------------------------------------------
module point_sphere_push_out (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  psp_pkg::req_type                    req_data,
   output logic                                rsp_strobe,
   output psp_pkg::rsp_type                    rsp_data,
   input  logic                                csr_we,
   input  logic [psp_pkg::CSR_IDX_WIDTH-1:0]   csr_index,
   input  logic [psp_pkg::COORD_WIDTH-1:0]     csr_wdata
);
   import psp_pkg::*;

   localparam int CW = COORD_WIDTH;
   localparam int RW = RAD_WIDTH;
   localparam int DW = CW + 1;
   localparam logic signed [DW-1:0] SAT_MAX = DW'((1 << (CW - 1)) - 1);
   localparam logic signed [DW-1:0] SAT_MIN = -DW'(1 << (CW - 1));

   typedef struct packed {
      logic               hit;
      logic               nz;
      logic [2:0]         neg;
      logic [2:0][RW-1:0] mag;
      logic [2:0][CW-1:0] pt;
   } sq_pay_type;

   typedef struct packed {
      logic               hit;
      logic               nz;
      logic [2:0]         neg;
      logic [2:0][CW-1:0] pt;
   } dv_pay_type;

   // sphere registers
   logic [2:0][CW-1:0] center_ff;
   logic [RW-1:0]      radius_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff <= '0;
         radius_ff <= RADIUS_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CENTER_X: center_ff[0] <= csr_wdata;
            CSR_CENTER_Y: center_ff[1] <= csr_wdata;
            CSR_CENTER_Z: center_ff[2] <= csr_wdata;
            CSR_RADIUS:   radius_ff    <= csr_wdata[RW-1:0];
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   // stage 1: difference to center
   logic [2:0][CW-1:0]        pt_in;
   logic [2:0][DW-1:0]        d_in;
   logic                      s1_valid_ff;
   logic [2:0][CW-1:0]        s1_pt_ff;
   logic [2:0][DW-1:0]        s1_d_ff;

   always_comb begin
      pt_in[0] = req_data.point_x;
      pt_in[1] = req_data.point_y;
      pt_in[2] = req_data.point_z;
      for (int i = 0; i < 3; i++) begin
         d_in[i] = {pt_in[i][CW-1], pt_in[i]} - {center_ff[i][CW-1], center_ff[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start;
      end
      s1_pt_ff <= pt_in;
      s1_d_ff  <= d_in;
   end

   // stage 2: magnitudes and the per-axis reach check
   logic [2:0][DW-1:0] mag_full;
   logic               near_in;
   logic               s2_valid_ff;
   logic [2:0][CW-1:0] s2_pt_ff;
   logic [2:0][RW-1:0] s2_mag_ff;
   logic [2:0]         s2_neg_ff;
   logic               s2_near_ff;
   logic               s2_nz_ff;

   always_comb begin
      near_in = 1'b1;
      for (int i = 0; i < 3; i++) begin
         mag_full[i] = s1_d_ff[i][DW-1] ? DW'(-s1_d_ff[i]) : s1_d_ff[i];
         if (mag_full[i] >= {2'b00, radius_ff}) begin
            near_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_pt_ff   <= s1_pt_ff;
      for (int i = 0; i < 3; i++) begin
         s2_mag_ff[i] <= mag_full[i][RW-1:0];
         s2_neg_ff[i] <= s1_d_ff[i][DW-1];
      end
      s2_near_ff <= near_in;
      s2_nz_ff   <= (mag_full != '0);
   end

   // stage 3: squares and squared radius
   logic               s3_valid_ff;
   logic [2:0][CW-1:0] s3_pt_ff;
   logic [2:0][RW-1:0] s3_mag_ff;
   logic [2:0]         s3_neg_ff;
   logic               s3_near_ff;
   logic               s3_nz_ff;
   logic [2:0][2*RW-1:0] s3_sq_ff;
   logic [2*RW-1:0]    s3_r2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
      s3_pt_ff   <= s2_pt_ff;
      s3_mag_ff  <= s2_mag_ff;
      s3_neg_ff  <= s2_neg_ff;
      s3_near_ff <= s2_near_ff;
      s3_nz_ff   <= s2_nz_ff;
      for (int i = 0; i < 3; i++) begin
         s3_sq_ff[i] <= {{RW{1'b0}}, s2_mag_ff[i]} * {{RW{1'b0}}, s2_mag_ff[i]};
      end
      s3_r2_ff <= {{RW{1'b0}}, radius_ff} * {{RW{1'b0}}, radius_ff};
   end

   // stage 4: squared distance and the inside test
   logic [2*RW+1:0] sum_in;
   logic            hit_in;
   logic            s4_valid_ff;
   logic [2*RW-1:0] s4_sum_ff;
   sq_pay_type      s4_pay_ff;

   always_comb begin
      sum_in = {2'b00, s3_sq_ff[0]} + {2'b00, s3_sq_ff[1]} + {2'b00, s3_sq_ff[2]};
      hit_in = s3_near_ff && (sum_in < {2'b00, s3_r2_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= s3_valid_ff;
      end
      s4_sum_ff     <= sum_in[2*RW-1:0];
      s4_pay_ff.hit <= hit_in;
      s4_pay_ff.nz  <= s3_nz_ff;
      s4_pay_ff.neg <= s3_neg_ff;
      s4_pay_ff.mag <= s3_mag_ff;
      s4_pay_ff.pt  <= s3_pt_ff;
   end

   // distance: floor of the square root
   logic          sq_valid;
   logic [RW-1:0] sq_root;
   sq_pay_type    sq_pay;

   psp_sqrt #(
      .RW (RW),
      .PW ($bits(sq_pay_type))
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s4_valid_ff),
      .in_rad    (s4_sum_ff),
      .in_pay    (s4_pay_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_pay   (sq_pay)
   );

   // scale each magnitude by the radius, add half the distance for rounding
   logic                 s5_valid_ff;
   logic [2:0][2*RW:0]   s5_num_ff;
   logic [RW-1:0]        s5_den_ff;
   dv_pay_type           s5_pay_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else begin
         s5_valid_ff <= sq_valid;
      end
      for (int i = 0; i < 3; i++) begin
         s5_num_ff[i] <= {1'b0, {RW{1'b0}}, sq_pay.mag[i]} * {{(RW+1){1'b0}}, radius_ff}
                         + {{(RW+2){1'b0}}, sq_root[RW-1:1]};
      end
      s5_den_ff     <= sq_root;
      s5_pay_ff.hit <= sq_pay.hit;
      s5_pay_ff.nz  <= sq_pay.nz;
      s5_pay_ff.neg <= sq_pay.neg;
      s5_pay_ff.pt  <= sq_pay.pt;
   end

   // divide by the distance
   logic               dv_valid;
   logic [2:0][RW-1:0] dv_quo;
   dv_pay_type         dv_pay;

   psp_div #(
      .RW (RW),
      .PW ($bits(dv_pay_type))
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s5_valid_ff),
      .in_num    (s5_num_ff),
      .in_den    (s5_den_ff),
      .in_pay    (s5_pay_ff),
      .out_valid (dv_valid),
      .out_quo   (dv_quo),
      .out_pay   (dv_pay)
   );

   // output: offset from center, saturate, or pass the point
   logic [2:0][CW-1:0]  res_in;
   logic signed [DW-1:0] off;
   logic signed [DW-1:0] pos;
   logic                rsp_strobe_ff;
   rsp_type             rsp_data_ff;

   always_comb begin
      off = '0;
      pos = '0;
      for (int i = 0; i < 3; i++) begin
         off = dv_pay.neg[i] ? -$signed({2'b00, dv_quo[i]}) : $signed({2'b00, dv_quo[i]});
         pos = $signed({center_ff[i][CW-1], center_ff[i]}) + off;
         if (!(dv_pay.hit && dv_pay.nz)) begin
            res_in[i] = dv_pay.pt[i];
         end else if (pos > SAT_MAX) begin
            res_in[i] = SAT_MAX[CW-1:0];
         end else if (pos < SAT_MIN) begin
            res_in[i] = SAT_MIN[CW-1:0];
         end else begin
            res_in[i] = pos[CW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= dv_valid;
      end
      rsp_data_ff.out_x    <= res_in[0];
      rsp_data_ff.out_y    <= res_in[1];
      rsp_data_ff.out_z    <= res_in[2];
      rsp_data_ff.collided <= dv_pay.hit;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule
